// ----- sv/psa_pkg.sv -----
// Package: status codes, commands and shared widths for the pooled slot allocator.
`default_nettype none
package psa_pkg;
	localparam int CMD_W = 1;
	localparam int POOL_W = 3;
	localparam int SLOT_W = 10;
	localparam int CFG_W = 11;
	localparam int STATUS_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NO_POOL   = 2'd1,
		ST_NOT_LIVE  = 2'd2,
		ST_DBL_FREE  = 2'd3
	} status_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [POOL_W-1:0] pool_id;
		logic [SLOT_W-1:0] slot;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POOL_W-1:0]   granted_pool;
		logic [SLOT_W-1:0]   granted_slot;
	} rsp_t;
endpackage
`default_nettype wire

// ----- sv/psa_if.sv -----
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface psa_req_if;
	logic           valid;
	logic           ready;
	psa_pkg::req_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface psa_rsp_if;
	logic           valid;
	logic           ready;
	psa_pkg::rsp_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/pooled_slot_allocator.sv -----
// Top level: sequencer, per-pool state and the link memory of the slot allocator.
// The allocator handles one request at a time. An allocate from a pool with a free
// slot runs through the alloc and take states, plus a link read for a listed slot;
// when the current pool is full, the sequencer first scans the pool order, one entry
// per cycle, up to twice (free list, then room), then swaps the chosen pool in. A free
// checks whether the pool is open by stepping through every entry of the pool order
// and then walks the sorted free list through the link memory, each node a read and
// then the registered data. One result per request goes out through an output
// register; the next request is taken once that result's transfer has happened. No
// clearing pass is needed after reset: only listed slots are ever read from the link
// memory.
`default_nettype none
module pooled_slot_allocator #(
	parameter int NUM_POOLS = 8,
	parameter int MAX_POOL_SLOTS = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	psa_req_if.sink                       req,
	psa_rsp_if.source                     rsp,
	input  wire logic                     cfg_we,
	input  wire logic [psa_pkg::CFG_W-1:0] cfg_wdata
);
	localparam int PI_W = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;  // pool index
	localparam int PC_W = $clog2(NUM_POOLS + 1);                     // pool count
	localparam int SI_W = $clog2(MAX_POOL_SLOTS);                    // slot index
	localparam int LK_W = SI_W + 1;                                  // link / mark
	localparam int MEM_W = PI_W + SI_W;
	localparam logic [LK_W-1:0] END_MARK = LK_W'(2 * MAX_POOL_SLOTS - 1);
	localparam logic [LK_W-1:0] MAX_S = LK_W'(MAX_POOL_SLOTS);
	localparam logic [PC_W-1:0] NPOOLS = PC_W'(NUM_POOLS);

	typedef enum logic [3:0] {
		S_IDLE, S_ALLOC, S_SCAN_FREE, S_SCAN_ROOM, S_SWAP, S_TAKE, S_TAKE_RD,
		S_CHK_OPEN, S_FREE_CHK, S_WALK_RD, S_WALK, S_INSERT, S_RESP
	} state_t;

	state_t                     state_q;
	logic [psa_pkg::CFG_W-1:0]  pool_slots_q;
	logic [PI_W-1:0]            order_q [NUM_POOLS];
	logic [PC_W-1:0]            open_q;
	logic [LK_W-1:0]            hw_q    [NUM_POOLS];
	logic [LK_W-1:0]            head_q  [NUM_POOLS];
	logic [LK_W-1:0]            link_mem [2**MEM_W];
	logic [LK_W-1:0]            rd_q;
	logic [PC_W-1:0]            idx_q;
	logic [PI_W-1:0]            pool_q;
	logic [SI_W-1:0]            slot_q;
	logic                       opn_q;
	logic [LK_W-1:0]            prev_q;
	logic [LK_W-1:0]            nx_q;
	logic [LK_W-1:0]            steps_q;
	psa_pkg::rsp_t              out_q;
	logic                       out_vld_q;
	logic                       mem_we;
	logic [MEM_W-1:0]           mem_wa;
	logic [LK_W-1:0]            mem_wd;
	logic [MEM_W-1:0]           mem_ra;
	logic [LK_W-1:0]            eff;
	logic [PI_W-1:0]            cur;
	logic [PI_W-1:0]            scan_p;
	logic [LK_W-1:0]            nxt;      // decoded next from rd_q
	logic [LK_W+1:0]            nsum;

	// effective limit: 0 acts as 1, clamp to MAX_POOL_SLOTS
	always_comb begin
		if (pool_slots_q == '0) eff = LK_W'(1);
		else if ({1'b0, pool_slots_q} > (psa_pkg::CFG_W+1)'(MAX_POOL_SLOTS)) eff = MAX_S;
		else eff = LK_W'(pool_slots_q);
	end

	assign cur    = order_q[PI_W'(open_q - PC_W'(1))];
	assign scan_p = order_q[PI_W'(idx_q)];
	assign nsum   = (LK_W+2)'(nx_q) + (LK_W+2)'(rd_q);
	always_comb begin
		if (rd_q == END_MARK || rd_q == '0 || nsum >= (LK_W+2)'(MAX_POOL_SLOTS)) nxt = END_MARK;
		else nxt = LK_W'(nsum);
	end

	assign req.ready = (state_q == S_IDLE) && !out_vld_q;
	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pool_slots_q <= psa_pkg::CFG_W'(1024);
		else if (cfg_we) pool_slots_q <= cfg_wdata;
	end

	// link memory: one write and one read port, read data registered
	always_ff @(posedge clk) begin
		if (mem_we) link_mem[mem_wa] <= mem_wd;
		rd_q <= link_mem[mem_ra];
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = {pool_q, slot_q};
		mem_wd = END_MARK;
		mem_ra = {pool_q, nx_q[SI_W-1:0]};
		if (state_q == S_TAKE) mem_ra = {cur, head_q[cur][SI_W-1:0]};
		if (state_q == S_INSERT && !(LK_W'(slot_q) + LK_W'(1) == hw_q[pool_q])
			&& !(nx_q == LK_W'(slot_q))) begin
			mem_we = 1'b1;
			mem_wd = (nx_q == END_MARK || nx_q < LK_W'(slot_q)) ? END_MARK
				: nx_q - LK_W'(slot_q);
		end
		if (state_q == S_RESP && prev_q != END_MARK && opn_q) begin
			mem_we = 1'b1;
			mem_wa = {pool_q, prev_q[SI_W-1:0]};
			mem_wd = LK_W'(slot_q) - prev_q;
		end
	end

	// sequencer: one compare/add unit per cycle over the pool order or list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			open_q    <= '0;
			out_vld_q <= 1'b0;
			for (int i = 0; i < NUM_POOLS; i++) begin
				order_q[i] <= PI_W'(i);
				hw_q[i]    <= '0;
				head_q[i]  <= END_MARK;
			end
			idx_q <= '0; pool_q <= '0; slot_q <= '0; opn_q <= 1'b0;
			prev_q <= '0; nx_q <= '0; steps_q <= '0; out_q <= '0;
		end else begin
			if (out_vld_q && rsp.ready) out_vld_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						pool_q <= req.data.pool_id[PI_W-1:0];
						slot_q <= req.data.slot[SI_W-1:0];
						idx_q  <= '0;
						opn_q  <= 1'b0;
						if (psa_pkg::cmd_t'(req.data.command) == psa_pkg::CMD_ALLOC) begin
							out_q   <= '0;
							state_q <= S_ALLOC;
						end else if (PI_W < psa_pkg::POOL_W &&
							req.data.pool_id >= psa_pkg::POOL_W'(NUM_POOLS)) begin
							out_q <= psa_pkg::rsp_t'{status: psa_pkg::ST_NOT_LIVE,
								granted_pool: '0, granted_slot: '0};
							out_vld_q <= 1'b1;
						end else begin
							out_q   <= '0;
							state_q <= S_CHK_OPEN;
						end
					end
				end
				S_ALLOC: begin
					if (open_q == '0) begin
						open_q  <= PC_W'(1);
						state_q <= S_TAKE;
					end else if (head_q[cur] == END_MARK && !(hw_q[cur] < eff))
						state_q <= S_SCAN_FREE;
					else state_q <= S_TAKE;
				end
				S_SCAN_FREE: begin
					if (head_q[scan_p] != END_MARK) state_q <= S_SWAP;
					else if (idx_q == open_q - PC_W'(1)) begin
						idx_q   <= '0;
						state_q <= S_SCAN_ROOM;
					end else idx_q <= idx_q + PC_W'(1);
				end
				S_SCAN_ROOM: begin
					if (hw_q[scan_p] < eff) state_q <= S_SWAP;
					else if (idx_q == open_q - PC_W'(1)) begin
						if (open_q >= NPOOLS) begin
							out_q.status <= psa_pkg::ST_NO_POOL;
							out_vld_q    <= 1'b1;
							state_q      <= S_IDLE;
						end else begin
							idx_q   <= open_q;
							open_q  <= open_q + PC_W'(1);
							state_q <= S_SWAP;
						end
					end else idx_q <= idx_q + PC_W'(1);
				end
				S_SWAP: begin
					// chosen pool already current: nothing to exchange
					if (PI_W'(idx_q) != PI_W'(open_q - PC_W'(1))) begin
						order_q[PI_W'(idx_q)] <= cur;
						order_q[PI_W'(open_q - PC_W'(1))] <= scan_p;
					end
					state_q <= S_TAKE;
				end
				S_TAKE: begin
					out_q.granted_pool <= psa_pkg::POOL_W'(cur);
					pool_q <= cur;
					if (head_q[cur] != END_MARK) begin
						out_q.granted_slot <= psa_pkg::SLOT_W'(head_q[cur][SI_W-1:0]);
						nx_q    <= head_q[cur];
						state_q <= S_TAKE_RD;
					end else begin
						out_q.granted_slot <= psa_pkg::SLOT_W'(hw_q[cur][SI_W-1:0]);
						hw_q[cur] <= hw_q[cur] + LK_W'(1);
						out_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				S_TAKE_RD: begin
					head_q[pool_q] <= nxt;
					out_vld_q <= 1'b1;
					state_q   <= S_IDLE;
				end
				S_CHK_OPEN: begin
					if (idx_q < open_q && order_q[PI_W'(idx_q)] == pool_q) opn_q <= 1'b1;
					if (idx_q == NPOOLS - PC_W'(1)) state_q <= S_FREE_CHK;
					else idx_q <= idx_q + PC_W'(1);
				end
				S_FREE_CHK: begin
					if (!opn_q || !(LK_W'(slot_q) < hw_q[pool_q])) begin
						out_q.status <= psa_pkg::ST_NOT_LIVE;
						out_vld_q    <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						prev_q  <= END_MARK;
						nx_q    <= head_q[pool_q];
						steps_q <= '0;
						state_q <= S_WALK_RD;
					end
				end
				S_WALK_RD: begin
					if (nx_q != END_MARK && nx_q < LK_W'(slot_q) && steps_q < MAX_S)
						state_q <= S_WALK;
					else state_q <= S_INSERT;
				end
				S_WALK: begin
					prev_q  <= nx_q;
					nx_q    <= nxt;
					steps_q <= steps_q + LK_W'(1);
					state_q <= S_WALK_RD;
				end
				S_INSERT: begin
					if (nx_q == LK_W'(slot_q)) begin
						out_q.status <= psa_pkg::ST_DBL_FREE;
						out_vld_q    <= 1'b1;
						state_q      <= S_IDLE;
					end else if (LK_W'(slot_q) + LK_W'(1) == hw_q[pool_q]) begin
						hw_q[pool_q] <= LK_W'(slot_q);
						out_vld_q    <= 1'b1;
						state_q      <= S_IDLE;
					end else state_q <= S_RESP;
				end
				S_RESP: begin
					if (prev_q == END_MARK) head_q[pool_q] <= LK_W'(slot_q);
					out_vld_q <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a result is only produced from idle-bound states
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> state_q == S_IDLE)
		else $error("result raised outside completion");
	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= NPOOLS)
		else $error("open pool count overflow");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !req.ready)
		else $error("accepted while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !rsp.ready |=> out_vld_q && $stable(out_q))
		else $error("result dropped before transfer");
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench for the pooled slot allocator: directed table plus predictor-checked random traffic.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	localparam int NPOOL    = 8;
	localparam int MAXSLOTS = 1024;
	// end-of-list marker used by the link encoding
	localparam int unsigned LINK_END = 2 * MAXSLOTS - 1;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [psa_pkg::CFG_W-1:0]   cfg_wdata;

	psa_req_if req_ch ();
	psa_rsp_if rsp_ch ();

	pooled_slot_allocator #(
		.NUM_POOLS(NPOOL),
		.MAX_POOL_SLOTS(MAXSLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Shadow copy of the allocator: pool order, marks, free lists, links.
	// ---------------------------------------------------------------------
	logic [psa_pkg::CFG_W-1:0] slots_limit;
	int unsigned      order_tab [NPOOL];
	int unsigned      open_cnt;
	int unsigned      mark_tab [NPOOL];
	int unsigned      head_tab [NPOOL];
	int unsigned      link_mem [NPOOL*MAXSLOTS];

	psa_pkg::rsp_t grant_q [$];   // responses still owed by the block
	int   err_cnt = 0;
	bit   no_idle;       // stretch with no gaps on either side

	function automatic int unsigned usable_slots();
		if (slots_limit == 0) return 1;
		if (slots_limit > MAXSLOTS) return MAXSLOTS;
		return slots_limit;
	endfunction

	// next listed slot after cur; damaged or out-of-range links end the walk
	function automatic int unsigned next_free(int unsigned p, int unsigned cur);
		int unsigned d;
		int unsigned n;
		d = link_mem[p*MAXSLOTS + cur];
		if (d == LINK_END || d == 0) return LINK_END;
		n = cur + d;
		if (n >= MAXSLOTS) return LINK_END;
		return n;
	endfunction

	function automatic bit pool_has_room(int unsigned p);
		return mark_tab[p] < usable_slots();
	endfunction

	function automatic void shadow_reset();
		slots_limit = 11'd1024;
		open_cnt = 0;
		for (int i = 0; i < NPOOL; i++) begin
			order_tab[i] = i;
			mark_tab[i] = 0;
			head_tab[i] = LINK_END;
		end
		for (int i = 0; i < NPOOL*MAXSLOTS; i++) link_mem[i] = 0;
	endfunction

	function automatic psa_pkg::rsp_t grant_for(psa_pkg::req_t r);
		psa_pkg::rsp_t res;
		int unsigned n, cur, idx, s, p, prev, nx, steps, tmp;
		bit          found, is_open;
		res = '0;
		res.status = psa_pkg::ST_OK;
		if (r.command == psa_pkg::CMD_ALLOC) begin
			n = open_cnt;
			if (n == 0) begin
				open_cnt = 1;
				n = 1;
			end else begin
				cur = order_tab[n-1];
				if (head_tab[cur] == LINK_END && !pool_has_room(cur)) begin
					found = 0;
					idx = 0;
					// first a pool with a free list, then one with room
					for (int i = 0; i < n; i++)
						if (!found && head_tab[order_tab[i]] != LINK_END) begin
							idx = i;
							found = 1;
						end
					for (int i = 0; i < n; i++)
						if (!found && pool_has_room(order_tab[i])) begin
							idx = i;
							found = 1;
						end
					if (!found) begin
						if (n >= NPOOL) begin
							res.status = psa_pkg::ST_NO_POOL;
							return res;
						end
						idx = n;
						n++;
						open_cnt = n;
					end
					tmp = order_tab[idx];
					order_tab[idx] = order_tab[n-1];
					order_tab[n-1] = tmp;
				end
			end
			cur = order_tab[n-1];
			if (head_tab[cur] != LINK_END) begin
				s = head_tab[cur];
				head_tab[cur] = next_free(cur, s);
			end else begin
				s = mark_tab[cur];
				mark_tab[cur] = s + 1;
			end
			res.granted_pool = cur[psa_pkg::POOL_W-1:0];
			res.granted_slot = s[psa_pkg::SLOT_W-1:0];
			return res;
		end
		p = r.pool_id;
		s = r.slot;
		is_open = 0;
		for (int i = 0; i < NPOOL; i++)
			if (i < open_cnt && order_tab[i] == p) is_open = 1;
		if (!is_open || s >= mark_tab[p]) begin
			res.status = psa_pkg::ST_NOT_LIVE;
			return res;
		end
		prev = LINK_END;
		nx = head_tab[p];
		steps = 0;
		while (nx != LINK_END && nx < s && steps < MAXSLOTS) begin
			prev = nx;
			nx = next_free(p, nx);
			steps++;
		end
		if (nx == s) begin
			res.status = psa_pkg::ST_DBL_FREE;
			return res;
		end
		// top slot: only the mark drops
		if (s + 1 == mark_tab[p]) begin
			mark_tab[p] = s;
			return res;
		end
		link_mem[p*MAXSLOTS + s] = (nx == LINK_END || nx < s) ? LINK_END : nx - s;
		if (prev == LINK_END) head_tab[p] = s;
		else link_mem[p*MAXSLOTS + prev] = s - prev;
		return res;
	endfunction

	// ---------------------------------------------------------------------
	// Helpers for idling and driving
	// ---------------------------------------------------------------------
	function automatic int unsigned idle_len();
		if (no_idle) return 0;
		if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
		return $urandom_range(3, 40);
	endfunction

	// drive one request; it is a transfer once ready is seen at a rising edge
	task automatic push_req(psa_pkg::req_t r, bit typed, psa_pkg::rsp_t want);
		psa_pkg::rsp_t got;
		req_ch.valid = 1'b1;
		req_ch.data = r;
		forever begin
			@(posedge clk);
			if (req_ch.ready) break;
		end
		got = grant_for(r);
		grant_q.push_back(typed ? want : got);
		@(negedge clk);
		if (idle_len() > 0) begin
			req_ch.valid = 1'b0;
			repeat (idle_len()) @(negedge clk);
		end
	endtask

	task automatic drain();
		req_ch.valid = 1'b0;
		while (grant_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(logic [psa_pkg::CFG_W-1:0] v);
		drain();
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		slots_limit = v;
	endtask

	// ---------------------------------------------------------------------
	// Response side: random backpressure, check at the rising edge
	// ---------------------------------------------------------------------
	int unsigned stall_left = 0;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready = 1'b0;
		end else begin
			rsp_ch.ready = 1'b1;
			if ($urandom_range(0, 3) == 0) stall_left = idle_len();
		end
	end

	always @(posedge clk) begin
		psa_pkg::rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (grant_q.size() == 0) begin
				$error("response transfer with nothing outstanding: %h", rsp_ch.data);
				err_cnt++;
			end else begin
				want = grant_q.pop_front();
				if (rsp_ch.data.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.data.status);
					err_cnt++;
				end
				if (rsp_ch.data.granted_pool !== want.granted_pool) begin
					$error("granted_pool: expected %0d, got %0d",
						want.granted_pool, rsp_ch.data.granted_pool);
					err_cnt++;
				end
				if (rsp_ch.data.granted_slot !== want.granted_slot) begin
					$error("granted_slot: expected %0d, got %0d",
						want.granted_slot, rsp_ch.data.granted_slot);
					err_cnt++;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Directed table. typed=1 rows carry an expectation read off by hand;
	// the rest are checked against the shadow model.
	// ---------------------------------------------------------------------
	typedef struct {
		psa_pkg::cmd_t    cmd;
		int unsigned      pool;
		int unsigned      slot;
		bit               typed;
		psa_pkg::status_t st;
		int unsigned      gpool;
		int unsigned      gslot;
	} row_t;

	row_t plan [] = '{
		'{psa_pkg::CMD_FREE,  0, 0,    1, psa_pkg::ST_NOT_LIVE, 0, 0},  // nothing open
		'{psa_pkg::CMD_ALLOC, 0, 0,    1, psa_pkg::ST_OK,       0, 0},
		'{psa_pkg::CMD_ALLOC, 7, 1023, 1, psa_pkg::ST_OK,       0, 1},  // free fields ignored
		'{psa_pkg::CMD_ALLOC, 0, 0,    1, psa_pkg::ST_OK,       0, 2},
		'{psa_pkg::CMD_FREE,  5, 0,    1, psa_pkg::ST_NOT_LIVE, 0, 0},  // pool not open
		'{psa_pkg::CMD_FREE,  7, 1023, 1, psa_pkg::ST_NOT_LIVE, 0, 0},
		'{psa_pkg::CMD_FREE,  0, 3,    1, psa_pkg::ST_NOT_LIVE, 0, 0},  // at the mark
		'{psa_pkg::CMD_FREE,  0, 1023, 1, psa_pkg::ST_NOT_LIVE, 0, 0},
		'{psa_pkg::CMD_FREE,  0, 0,    1, psa_pkg::ST_OK,       0, 0},
		'{psa_pkg::CMD_FREE,  0, 0,    1, psa_pkg::ST_DBL_FREE, 0, 0},
		'{psa_pkg::CMD_FREE,  0, 1,    1, psa_pkg::ST_OK,       0, 0},
		'{psa_pkg::CMD_FREE,  0, 1,    1, psa_pkg::ST_DBL_FREE, 0, 0},
		'{psa_pkg::CMD_FREE,  0, 2,    1, psa_pkg::ST_OK,       0, 0},  // mark drops to 2
		'{psa_pkg::CMD_FREE,  0, 2,    1, psa_pkg::ST_NOT_LIVE, 0, 0},
		'{psa_pkg::CMD_ALLOC, 0, 0,    1, psa_pkg::ST_OK,       0, 0},  // list head first
		'{psa_pkg::CMD_ALLOC, 0, 0,    1, psa_pkg::ST_OK,       0, 1},
		'{psa_pkg::CMD_ALLOC, 0, 0,    1, psa_pkg::ST_OK,       0, 2},  // then the mark
		'{psa_pkg::CMD_FREE,  0, 1,    0, psa_pkg::ST_OK,       0, 0},
		'{psa_pkg::CMD_FREE,  0, 0,    0, psa_pkg::ST_OK,       0, 0},
		'{psa_pkg::CMD_ALLOC, 3, 512,  0, psa_pkg::ST_OK,       0, 0},
		'{psa_pkg::CMD_FREE,  0, 2,    0, psa_pkg::ST_OK,       0, 0},
		'{psa_pkg::CMD_FREE,  0, 1,    0, psa_pkg::ST_OK,       0, 0},
		'{psa_pkg::CMD_FREE,  0, 0,    0, psa_pkg::ST_OK,       0, 0}
	};

	// limit settings walked by the random phases; extremes included
	int unsigned limits [] = '{1, 0, 2, 2047, 3, 1024, 17, 5, 64, 1025, 1};

	initial begin
		psa_pkg::req_t r;
		psa_pkg::rsp_t want;
		int unsigned   alloc_pct, p;
		no_idle = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		shadow_reset();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			r.command = plan[i].cmd;
			r.pool_id = psa_pkg::POOL_W'(plan[i].pool);
			r.slot = psa_pkg::SLOT_W'(plan[i].slot);
			want.status = plan[i].st;
			want.granted_pool = psa_pkg::POOL_W'(plan[i].gpool);
			want.granted_slot = psa_pkg::SLOT_W'(plan[i].gslot);
			push_req(r, plan[i].typed, want);
		end

		// random phases, one limit each; the drain in write_limit also makes
		// the sender hold off until every response is back
		foreach (limits[k]) begin
			write_limit(psa_pkg::CFG_W'(limits[k]));
			no_idle = (k % 4 == 3);
			alloc_pct = $urandom_range(40, 75);
			for (int n = 0; n < 145; n++) begin
				want = '0;
				if ($urandom_range(0, 99) < alloc_pct) begin
					r.command = psa_pkg::CMD_ALLOC;
					r.pool_id = psa_pkg::POOL_W'($urandom_range(0, 7));
					r.slot = psa_pkg::SLOT_W'($urandom_range(0, 1023));
				end else if ($urandom_range(0, 9) < 8 && open_cnt > 0) begin
					// mostly frees inside a live range, dups included
					r.command = psa_pkg::CMD_FREE;
					p = order_tab[$urandom_range(0, open_cnt - 1)];
					r.pool_id = psa_pkg::POOL_W'(p);
					r.slot = psa_pkg::SLOT_W'($urandom_range(0, mark_tab[p]));
				end else begin
					r.command = psa_pkg::CMD_FREE;
					r.pool_id = psa_pkg::POOL_W'($urandom_range(0, 7));
					r.slot = psa_pkg::SLOT_W'($urandom_range(0, 1023));
				end
				push_req(r, 0, want);
			end
		end

		drain();
		repeat (40) @(negedge clk);
		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#100000000;
		$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
